[rtl/bdq_pkg.sv]
// Shared types and codes for the bounded double-ended queue.
// Command and status encodings and fixed field widths; no dependencies.
package bdq_pkg;

  localparam int CMD_W = 3;
  localparam int ST_W  = 2;
  localparam int OCC_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_POP_FRONT  = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_FWD   = 3'd4,
    CMD_READ_BWD   = 3'd5,
    CMD_REMOVE     = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

[rtl/bounded_deque_with_value_removal.sv]
// Bounded double-ended queue held in a ring memory, top level.
// Depends on bdq_pkg for command and status codes.
//
// Usage: one command word enters on the in_ channel (in_tuser = command,
// in_tdata = value) and is accepted when in_tvalid and in_tready are high.
// Every command returns one result word on the out_ channel, except a
// readout of a non-empty queue, which returns one word per entry. The last
// word of each command carries out_tlast.
// Sequencing: push, clear, pop and any command on an empty queue go from the
// accept to S_EXEC or S_POP, which loads the output register once it is free
// (pop starts its ring memory read at the accept edge). in_tready returns
// after that, so no command is taken before the last is done. A readout
// alternates S_RD_ISSUE and S_RD_EMIT, one memory read per entry.
// Remove-value walks all n entries through the single read port and compacts
// them with the write port, then reports. in_tready is high only between
// commands. The output register holds a finished word while the receiver
// stalls; the block then waits with the next word and loses nothing.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// output word. The memory is not cleared: only live entries ever reach the output.
module bounded_deque_with_value_removal #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32,
  localparam int IN_TW     = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW    = ((DATA_WIDTH + 2 * bdq_pkg::OCC_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TW-1:0]           in_tdata,   // [DATA_WIDTH-1:0] value, rest zero
  input  logic [bdq_pkg::CMD_W-1:0]  in_tuser,   // [2:0] cmd
  // result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_TW-1:0]          out_tdata,  // data, occupancy(6), removed_count(6), zeros
  output logic [bdq_pkg::ST_W-1:0]   out_tuser,  // [1:0] status
  output logic                       out_tlast
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int OW = bdq_pkg::OCC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_POP, S_RD_ISSUE, S_RD_EMIT, S_RM_ISSUE, S_RM_CHECK, S_RM_DONE
  } state_t;

  state_t                state_r;
  bdq_pkg::cmd_t         cmd_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [IW-1:0]         head_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         idx_r;    // walk position
  logic [CW-1:0]         keep_r;   // entries kept so far by remove

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  bdq_pkg::status_t      out_status_r;
  logic [OW-1:0]         out_occ_r;
  logic [OW-1:0]         out_rem_r;
  logic                  out_last_r;

  // ring memory, one read and one write port, registered read
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;

  logic                  in_acc;
  logic                  out_free;
  logic                  emit;
  logic                  full;
  logic                  empty;
  bdq_pkg::cmd_t         in_cmd;
  logic [IW-1:0]         head_dec;
  logic [CW-1:0]         last_off;

  // Map a queue offset onto a ring slot.
  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(CAPACITY)) sum = sum - SW'(CAPACITY);
    return sum[IW-1:0];
  endfunction

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // load the output register this cycle
  assign emit      = out_free && (state_r inside {S_EXEC, S_POP, S_RD_EMIT, S_RM_DONE});
  assign in_cmd    = bdq_pkg::cmd_t'(in_tuser);
  assign full      = (count_r >= CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign head_dec  = (head_r == '0) ? IW'(CAPACITY - 1) : IW'(head_r - 1'b1);
  assign last_off  = CW'(count_r - 1'b1);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = head_r;
    case (state_r)
      S_IDLE: begin
        // start the pop read at accept so the word is ready next cycle
        if (in_acc && (in_cmd == bdq_pkg::CMD_POP_FRONT ||
                       in_cmd == bdq_pkg::CMD_POP_BACK)) begin
          mem_re    = 1'b1;
          mem_raddr = (in_cmd == bdq_pkg::CMD_POP_FRONT) ? head_r
                                                         : ring_pos(head_r, last_off);
        end
      end
      S_EXEC: begin
        if (out_free && !full && (cmd_r == bdq_pkg::CMD_PUSH_FRONT ||
                                  cmd_r == bdq_pkg::CMD_PUSH_BACK)) begin
          mem_we    = 1'b1;
          mem_waddr = (cmd_r == bdq_pkg::CMD_PUSH_FRONT) ? head_dec
                                                         : ring_pos(head_r, count_r);
        end
      end
      S_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = (cmd_r == bdq_pkg::CMD_READ_FWD)
                    ? ring_pos(head_r, idx_r)
                    : ring_pos(head_r, CW'(last_off - idx_r));
      end
      S_RM_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = ring_pos(head_r, idx_r);
      end
      S_RM_CHECK: begin
        // compact survivors toward the front; keep_r never passes idx_r
        if (rd_data_r != val_r) begin
          mem_we    = 1'b1;
          mem_waddr = ring_pos(head_r, keep_r);
          mem_wdata = rd_data_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // raise valid on an emit; drop the output word once it is taken
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r  <= in_cmd;
            val_r  <= in_tdata[DATA_WIDTH-1:0];
            idx_r  <= '0;
            keep_r <= '0;
            case (in_cmd)
              bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: state_r <= S_POP;
              bdq_pkg::CMD_READ_FWD, bdq_pkg::CMD_READ_BWD:
                state_r <= empty ? S_EXEC : S_RD_ISSUE;
              bdq_pkg::CMD_REMOVE: state_r <= empty ? S_EXEC : S_RM_ISSUE;
              default: state_r <= S_EXEC;
            endcase
          end
        end

        // single-word results: push, clear, and readout or remove on an empty queue
        S_EXEC: begin
          if (out_free) begin
            out_data_r  <= '0;
            out_rem_r   <= '0;
            out_last_r  <= 1'b1;
            out_occ_r   <= OW'(count_r);
            out_status_r <= bdq_pkg::ST_EMPTY;
            case (cmd_r)
              bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (full) begin
                  out_status_r <= bdq_pkg::ST_FULL;
                end else begin
                  out_status_r <= bdq_pkg::ST_OK;
                  count_r      <= CW'(count_r + 1'b1);
                  out_occ_r    <= OW'(CW'(count_r + 1'b1));
                  if (cmd_r == bdq_pkg::CMD_PUSH_FRONT) head_r <= head_dec;
                end
              end
              bdq_pkg::CMD_CLEAR: begin
                out_status_r <= bdq_pkg::ST_OK;
                count_r      <= '0;
                head_r       <= '0;
                out_occ_r    <= '0;
              end
              default: ;
            endcase
            state_r <= S_IDLE;
          end
        end

        S_POP: begin
          if (out_free) begin
            out_rem_r   <= '0;
            out_last_r  <= 1'b1;
            if (empty) begin
              out_data_r   <= '0;
              out_status_r <= bdq_pkg::ST_EMPTY;
              out_occ_r    <= '0;
            end else begin
              out_data_r   <= rd_data_r;
              out_status_r <= bdq_pkg::ST_OK;
              out_occ_r    <= OW'(last_off);
              count_r      <= last_off;
              if (cmd_r == bdq_pkg::CMD_POP_FRONT) head_r <= ring_pos(head_r, CW'(1));
            end
            state_r <= S_IDLE;
          end
        end

        S_RD_ISSUE: state_r <= S_RD_EMIT;

        S_RD_EMIT: begin
          if (out_free) begin
            out_data_r   <= rd_data_r;
            out_status_r <= bdq_pkg::ST_OK;
            out_occ_r    <= OW'(count_r);
            out_rem_r    <= '0;
            out_last_r   <= (idx_r == last_off);
            idx_r        <= CW'(idx_r + 1'b1);
            state_r      <= (idx_r == last_off) ? S_IDLE : S_RD_ISSUE;
          end
        end

        S_RM_ISSUE: state_r <= S_RM_CHECK;

        S_RM_CHECK: begin
          if (rd_data_r != val_r) keep_r <= CW'(keep_r + 1'b1);
          idx_r   <= CW'(idx_r + 1'b1);
          state_r <= (idx_r == last_off) ? S_RM_DONE : S_RM_ISSUE;
        end

        S_RM_DONE: begin
          if (out_free) begin
            out_data_r   <= '0;
            out_occ_r    <= OW'(keep_r);
            out_rem_r    <= OW'(CW'(count_r - keep_r));
            out_last_r   <= 1'b1;
            out_status_r <= (count_r == keep_r) ? bdq_pkg::ST_NOTFOUND : bdq_pkg::ST_OK;
            count_r      <= keep_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({out_rem_r, out_occ_r, out_data_r});
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/bdq_checker.sv]
// Port-level checks for the bounded double-ended queue, bound to the top.
// Depends on bdq_pkg and on the port list of bounded_deque_with_value_removal.
module bdq_checker #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32,
  localparam int OUT_TW    = ((DATA_WIDTH + 2 * bdq_pkg::OCC_W + 7) / 8) * 8
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_TW-1:0]        out_tdata,
  input logic [bdq_pkg::ST_W-1:0] out_tuser,
  input logic                     out_tlast
);

  localparam int OW = bdq_pkg::OCC_W;

  logic [OW-1:0] occ;
  logic [OW-1:0] rem;

  assign occ = out_tdata[DATA_WIDTH +: OW];
  assign rem = out_tdata[DATA_WIDTH + OW +: OW];

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result word changed");

  // one command at a time: ready drops after every accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted back to back");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= OW'(CAPACITY))
    else $error("occupancy beyond capacity");

  // error results and remove reports are single words with no data
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != bdq_pkg::ST_OK || rem != '0)
      |-> out_tlast && out_tdata[DATA_WIDTH-1:0] == '0)
    else $error("error or remove result not a lone zero-data word");

endmodule

bind bounded_deque_with_value_removal bdq_checker #(
  .CAPACITY(CAPACITY),
  .DATA_WIDTH(DATA_WIDTH)
) u_bdq_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser),
  .out_tlast(out_tlast)
);

[bench/bounded_deque_with_value_removal_test.sv]
// Self-checking bench for the bounded double-ended queue top level.
// Depends on bdq_pkg and bounded_deque_with_value_removal from the rtl folder.
`timescale 1ns / 1ps

module bounded_deque_with_value_removal_test;

  localparam int DEPTH       = 32;    // ring capacity of the block
  localparam int SETTLE      = 4;     // quiet cycles before a drained command
  localparam int TAIL_CYCLES = 80;    // wait after the last reply before the verdict
  localparam int IDLE_LIMIT  = 3000;  // cycles with no word moving on any side
  localparam int LONG_STALL  = 200;   // receiver hold-off that backs up the block
  localparam int NUM_ITEMS   = 350;

  // one command word waiting for the driver
  typedef struct {
    bdq_pkg::cmd_t op;
    logic [31:0]   value;
    int            gap;    // idle cycles before this word is offered
    bit            drain;  // hold until every reply has come back
  } cmd_item_t;

  // one reply word as the block should return it
  typedef struct packed {
    logic [31:0]      data;
    bdq_pkg::status_t status;
    logic [5:0]       occ;
    logic [5:0]       removed;
    logic             last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] value
  logic [2:0]  in_tuser = '0;    // [2:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [31:0] data, [37:32] occupancy, [43:38] removed_count
  logic [1:0]  out_tuser;        // [1:0] status
  logic        out_tlast;

  bounded_deque_with_value_removal dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow deque: ring memory, head and count kept at the block's widths.
  // ---------------------------------------------------------------------
  logic [31:0] ring_mem [DEPTH];
  logic [4:0]  ring_head = '0;
  logic [5:0]  ring_count = '0;

  cmd_item_t cmd_pending[$];
  reply_t    reply_q[$];

  int cmds_sent      = 0;
  int words_checked  = 0;
  int err_count      = 0;
  int full_refusals  = 0;
  int remove_misses  = 0;
  int longest_read   = 0;

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic add_reply(input logic [31:0] data, input bdq_pkg::status_t st,
                           input logic [5:0] removed, input logic last);
    reply_t r;
    r.data    = data;
    r.status  = st;
    r.occ     = ring_count;
    r.removed = removed;
    r.last    = last;
    reply_q.push_back(r);
  endtask

  // Apply one accepted command to the shadow deque and queue its replies.
  task automatic deque_step(input bdq_pkg::cmd_t op, input logic [31:0] v);
    logic [4:0]  pos;
    logic [31:0] word;
    int          kept;
    int          n;
    case (op)
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          full_refusals++;
          add_reply('0, bdq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          if (op == bdq_pkg::CMD_PUSH_FRONT) begin
            ring_head = ring_head - 5'd1;
            ring_mem[ring_head] = v;
          end else begin
            pos = ring_head + ring_count[4:0];
            ring_mem[pos] = v;
          end
          ring_count = ring_count + 6'd1;
          add_reply('0, bdq_pkg::ST_OK, '0, 1'b1);
        end
      end
      bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
        if (ring_count == 0) begin
          add_reply('0, bdq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          if (op == bdq_pkg::CMD_POP_FRONT) begin
            word = ring_mem[ring_head];
            ring_head = ring_head + 5'd1;
          end else begin
            pos = ring_head + ring_count[4:0] - 5'd1;
            word = ring_mem[pos];
          end
          ring_count = ring_count - 6'd1;
          add_reply(word, bdq_pkg::ST_OK, '0, 1'b1);
        end
      end
      bdq_pkg::CMD_READ_FWD, bdq_pkg::CMD_READ_BWD: begin
        if (ring_count == 0) begin
          add_reply('0, bdq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          n = ring_count;
          if (n > longest_read) longest_read = n;
          for (int i = 0; i < n; i++) begin
            pos = ring_head + 5'((op == bdq_pkg::CMD_READ_FWD) ? i : n - 1 - i);
            add_reply(ring_mem[pos], bdq_pkg::ST_OK, '0, i == n - 1);
          end
        end
      end
      bdq_pkg::CMD_REMOVE: begin
        if (ring_count == 0) begin
          add_reply('0, bdq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          // compact survivors toward the head, keeping their order
          kept = 0;
          for (int i = 0; i < ring_count; i++) begin
            pos = ring_head + 5'(i);
            word = ring_mem[pos];
            if (word != v) begin
              pos = ring_head + 5'(kept);
              ring_mem[pos] = word;
              kept++;
            end
          end
          n = ring_count - kept;
          ring_count = 6'(kept);
          if (n == 0) remove_misses++;
          add_reply('0, (n != 0) ? bdq_pkg::ST_OK : bdq_pkg::ST_NOTFOUND,
                    6'(n), 1'b1);
        end
      end
      default: begin
        ring_count = '0;
        ring_head  = '0;
        add_reply('0, bdq_pkg::ST_OK, '0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------
  logic [31:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h5a5a_5a5a,
                                  32'ha5a5_a5a5, 32'h0000_002a};
  int calm_items = 0;   // words still to be offered back to back

  function automatic logic [31:0] pick_value();
    // a small pool makes remove hit often; full random covers every bit
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic add_cmd(input bdq_pkg::cmd_t op, input logic [31:0] v,
                         input bit drain = 1'b0);
    cmd_item_t it;
    int        r;
    it.op    = op;
    it.value = v;
    it.drain = drain;
    r = $urandom_range(0, 99);
    if (calm_items > 0) begin
      calm_items--;
      it.gap = 0;
    end else if (r < 5) begin
      calm_items = $urandom_range(20, 50);
      it.gap = 0;
    end else if (r < 55) begin
      it.gap = 0;
    end else if (r < 90) begin
      it.gap = $urandom_range(1, 3);
    end else begin
      it.gap = $urandom_range(8, 40);
    end
    cmd_pending.push_back(it);
  endtask

  function automatic bdq_pkg::cmd_t pick_push();
    return ($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK;
  endfunction

  function automatic bdq_pkg::cmd_t pick_pop();
    return ($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer pending words, hold on backpressure, predict on accept.
  // ---------------------------------------------------------------------
  int gap_cnt    = 0;
  int settle_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        deque_step(bdq_pkg::cmd_t'(in_tuser), in_tdata);
        cmds_sent++;
      end
      // count quiet cycles after the last reply, for a drained command
      if (reply_q.size() == 0 && !out_tvalid) settle_cnt++;
      else settle_cnt = 0;

      if (in_tvalid && !in_tready) begin
        // hold the word until the block takes it
      end else if (cmd_pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (gap_cnt < cmd_pending[0].gap) begin
        gap_cnt++;
        in_tvalid <= 1'b0;
      end else if (cmd_pending[0].drain && settle_cnt < SETTLE) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= cmd_pending[0].value;
        in_tuser  <= cmd_pending[0].op;
        void'(cmd_pending.pop_front());
        gap_cnt = 0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random receiver stalls, a long hold-off now and then, and a
  // field-by-field check of every accepted reply against the oldest one due.
  // ---------------------------------------------------------------------
  int     stall_left      = 0;
  int     calm_cycles     = 0;
  int     next_long_stall = 60;
  int     pick;
  reply_t got;
  reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_checked++;
        got.data    = out_tdata[31:0];
        got.occ     = out_tdata[37:32];
        got.removed = out_tdata[43:38];
        got.status  = bdq_pkg::status_t'(out_tuser);
        got.last    = out_tlast;
        if (reply_q.size() == 0) begin
          flag_error($sformatf("unexpected word: data=%h st=%0d occ=%0d rem=%0d last=%b",
                               got.data, got.status, got.occ, got.removed, got.last));
        end else begin
          want = reply_q.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.occ !== want.occ || got.removed !== want.removed ||
              got.last !== want.last)
            flag_error($sformatf({"word %0d mismatch: exp data=%h st=%0d occ=%0d rem=%0d ",
                                  "last=%b, got data=%h st=%0d occ=%0d rem=%0d last=%b"},
                                 words_checked, want.data, want.status, want.occ,
                                 want.removed, want.last, got.data, got.status, got.occ,
                                 got.removed, got.last));
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (words_checked >= next_long_stall) begin
        // back up the block so it drops in_tready while the sender keeps offering
        stall_left = LONG_STALL;
        next_long_stall += 600;
        out_tready <= 1'b0;
      end else if (calm_cycles > 0) begin
        calm_cycles--;
        out_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_tready <= 1'b1;
        end else if (pick < 90) begin
          stall_left = $urandom_range(0, 2);
          out_tready <= 1'b0;
        end else if (pick < 97) begin
          stall_left = $urandom_range(8, 30);
          out_tready <= 1'b0;
        end else begin
          calm_cycles = $urandom_range(30, 90);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: give up when no word moves on either side for too long.
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d replies outstanding",
               idle_cycles, reply_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed corners, random sequences, drain, verdict.
  // ---------------------------------------------------------------------
  int  seq_kind;
  int  drain_marks;
  bit  mark_next;

  initial begin
    // directed: empty-queue corners first
    add_cmd(bdq_pkg::CMD_CLEAR,      32'h0);
    add_cmd(bdq_pkg::CMD_POP_FRONT,  32'h0);
    add_cmd(bdq_pkg::CMD_POP_BACK,   32'h0);
    add_cmd(bdq_pkg::CMD_READ_FWD,   32'h0);
    add_cmd(bdq_pkg::CMD_READ_BWD,   32'h0);
    add_cmd(bdq_pkg::CMD_REMOVE,     32'h0);
    // extreme values at both ends
    add_cmd(bdq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff);
    add_cmd(bdq_pkg::CMD_PUSH_BACK,  32'h8000_0000);
    add_cmd(bdq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
    add_cmd(bdq_pkg::CMD_PUSH_BACK,  32'h0000_0000);
    add_cmd(bdq_pkg::CMD_PUSH_BACK,  32'hffff_ffff);
    add_cmd(bdq_pkg::CMD_READ_FWD,   32'h0);
    add_cmd(bdq_pkg::CMD_READ_BWD,   32'h0);
    add_cmd(bdq_pkg::CMD_REMOVE,     32'h0001_2345);  // no match
    add_cmd(bdq_pkg::CMD_REMOVE,     32'hffff_ffff);  // two matches, order kept
    add_cmd(bdq_pkg::CMD_READ_FWD,   32'h0);
    add_cmd(bdq_pkg::CMD_POP_FRONT,  32'h0);
    add_cmd(bdq_pkg::CMD_POP_BACK,   32'h0);
    add_cmd(bdq_pkg::CMD_POP_FRONT,  32'h0);
    add_cmd(bdq_pkg::CMD_PUSH_BACK,  32'h0000_0005);
    add_cmd(bdq_pkg::CMD_CLEAR,      32'h0);           // clear a non-empty queue
    add_cmd(bdq_pkg::CMD_READ_FWD,   32'h0);

    // random part: mostly well-formed sequences, some noise
    drain_marks = 0;
    mark_next   = 1'b0;
    while (cmd_pending.size() < NUM_ITEMS) begin
      if (drain_marks < 2 && cmd_pending.size() >= 120 + 130 * drain_marks) begin
        mark_next = 1'b1;
        drain_marks++;
      end
      seq_kind = $urandom_range(0, 99);
      if (seq_kind < 12) begin
        // fill past capacity, then walk it both ways and prune it
        add_cmd(bdq_pkg::CMD_CLEAR, pick_value(), mark_next);
        mark_next = 1'b0;
        for (int i = 0; i < DEPTH + 2; i++) add_cmd(pick_push(), pick_value());
        add_cmd(bdq_pkg::CMD_READ_FWD, pick_value());
        add_cmd(bdq_pkg::CMD_READ_BWD, pick_value());
        add_cmd(bdq_pkg::CMD_REMOVE, value_pool[$urandom_range(0, 7)]);
        add_cmd(bdq_pkg::CMD_READ_FWD, pick_value());
      end else if (seq_kind < 55) begin
        // grow a little, look at it, remove something
        add_cmd(pick_push(), pick_value(), mark_next);
        mark_next = 1'b0;
        repeat ($urandom_range(1, 7)) add_cmd(pick_push(), pick_value());
        add_cmd(($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_READ_FWD
                                            : bdq_pkg::CMD_READ_BWD, pick_value());
        add_cmd(bdq_pkg::CMD_REMOVE, pick_value());
        if ($urandom_range(0, 1) != 0) add_cmd(pick_pop(), pick_value());
      end else if (seq_kind < 80) begin
        // shrink from either end, often past empty
        add_cmd(pick_pop(), pick_value(), mark_next);
        mark_next = 1'b0;
        repeat ($urandom_range(0, 6)) add_cmd(pick_pop(), pick_value());
      end else begin
        // noise: any command, any value
        add_cmd(bdq_pkg::cmd_t'($urandom_range(0, 7)), $urandom, mark_next);
        mark_next = 1'b0;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to be taken and every reply to return
    while (cmd_pending.size() != 0 || in_tvalid || reply_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (reply_q.size() != 0)
      flag_error($sformatf("%0d replies never arrived", reply_q.size()));

    $display("Ran %0d commands, checked %0d reply words, longest readout %0d entries",
             cmds_sent, words_checked, longest_read);
    $display("Pushes refused as full: %0d, removes without a match: %0d, errors: %0d",
             full_refusals, remove_misses, err_count);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/bdq_pkg.sv
rtl/bounded_deque_with_value_removal.sv
rtl/bdq_checker.sv
bench/bounded_deque_with_value_removal_test.sv
